>>> rtl/sha_pkg.sv
// sha_pkg: shared types, constants and round functions of the SHA-256 engine.
// Used by the controller, the datapath and the top level.
`default_nettype none
package sha_pkg;

	localparam int unsigned ROUNDS = 64;
	localparam int unsigned BLOCK_WORDS = 16;
	localparam int unsigned HASH_WORDS = 8;

	localparam logic [5:0] POS_LAST = 6'd63;
	localparam logic [5:0] POS_LEN = 6'd56;
	localparam logic [5:0] ROUND_LAST = 6'(ROUNDS - 1);
	localparam logic [2:0] WORD_LAST = 3'd7;
	localparam logic [7:0] PAD_MARK = 8'h80;
	localparam logic [63:0] LEN_STEP = 64'd8;

	localparam logic [31:0] HASH_IV [HASH_WORDS] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam logic [31:0] ROUND_K [ROUNDS] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MARK,
		ST_ZERO,
		ST_LEN,
		ST_ROUND,
		ST_FOLD,
		ST_OUT
	} sha_state_t;

	typedef enum logic [1:0] {
		BSEL_DATA,
		BSEL_MARK,
		BSEL_ZERO,
		BSEL_LEN
	} sha_bsel_t;

	typedef struct packed {
		logic       push;
		sha_bsel_t  bsel;
		logic       add_len;
		logic       init_work;
		logic       do_round;
		logic [5:0] round_idx;
		logic       fold;
		logic       rst_msg;
		logic [2:0] word_idx;
	} sha_cmd_t;

	typedef struct packed {
		logic [5:0] pos;
	} sha_sts_t;

	function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
		logic [63:0] d;
		d = {x, x} >> n;
		return d[31:0];
	endfunction

	function automatic logic [31:0] big_s0(input logic [31:0] x);
		return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
	endfunction

	function automatic logic [31:0] big_s1(input logic [31:0] x);
		return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
	endfunction

	function automatic logic [31:0] small_s0(input logic [31:0] x);
		return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
	endfunction

	function automatic logic [31:0] small_s1(input logic [31:0] x);
		return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
	endfunction

endpackage
`default_nettype wire

>>> rtl/sha_if.sv
// sha_byte_if and sha_digest_if: valid/ready channels of the SHA-256 engine.
// Message bytes come in on sha_byte_if, digest words leave on sha_digest_if.
`default_nettype none
interface sha_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       byte_present;
	logic       last_byte;

	modport source (output valid, output data_byte, output byte_present, output last_byte,
		input ready);
	modport sink (input valid, input data_byte, input byte_present, input last_byte,
		output ready);
endinterface

interface sha_digest_if;
	logic        valid;
	logic        ready;
	logic [31:0] digest_word;
	logic [2:0]  word_index;
	logic        last_word;

	modport source (output valid, output digest_word, output word_index, output last_word,
		input ready);
	modport sink (input valid, input digest_word, input word_index, input last_word,
		output ready);
endinterface
`default_nettype wire

>>> rtl/sha256_hash_engine.sv
// sha256_hash_engine: top level of the byte-serial SHA-256 engine.
// Depends on sha_pkg, sha_byte_if, sha_digest_if, sha_ctrl and sha_dp.
//
// channel  dir  handshake      payload
// msg      in   valid / ready  data_byte[7:0], byte_present, last_byte
// digest   out  valid / ready  digest_word[31:0], word_index[2:0], last_word
//
// A message byte is taken while idle; the 64th byte of a block starts the rounds
// and then the fold, all done by the single shared round unit.
// Padding feeds one byte per cycle outside the one or two block compressions (up to 72
// bytes, a pause before the length); then eight digest words, one per cycle when taken.
// arst_n clears the sequencer, byte position and length and loads the initial hash.
// msg.ready is high only while idle; a stalled digest word holds until taken.
`default_nettype none
module sha256_hash_engine (
	input wire           clk,
	input wire           arst_n,
	sha_byte_if.sink     msg,
	sha_digest_if.source digest
);
	import sha_pkg::*;

	sha_cmd_t cmd;
	sha_sts_t sts;
	logic [31:0] digest_word;

	sha_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (msg.valid),
		.byte_present (msg.byte_present),
		.last_byte    (msg.last_byte),
		.in_ready     (msg.ready),
		.out_valid    (digest.valid),
		.out_ready    (digest.ready),
		.sts          (sts),
		.cmd          (cmd)
	);

	sha_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.data_byte   (msg.data_byte),
		.sts         (sts),
		.digest_word (digest_word)
	);

	assign digest.digest_word = digest_word;
	assign digest.word_index = cmd.word_idx;
	assign digest.last_word = (cmd.word_idx == WORD_LAST);

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(msg.ready && digest.valid))
		else $error("input taken while digest pending");

	a_last_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		(msg.valid && msg.ready && msg.last_byte) |=> !msg.ready)
		else $error("input taken right after last byte");

	a_done_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(digest.valid && digest.ready && digest.last_word) |=>
		(msg.ready && sts.pos == '0))
		else $error("engine not reset after digest");

	a_pad_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		(digest.valid && digest.word_index == '0) |-> (sts.pos == '0))
		else $error("digest with partial block");

endmodule
`default_nettype wire

>>> rtl/sha_ctrl.sv
// sha_ctrl: sequencer of the SHA-256 engine (byte intake, padding, rounds, digest out).
// Depends on sha_pkg; drives sha_dp through sha_cmd_t and reads sha_sts_t.
`default_nettype none
module sha_ctrl (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               in_valid,
	input  wire               byte_present,
	input  wire               last_byte,
	output logic              in_ready,
	output logic              out_valid,
	input  wire               out_ready,
	input  wire sha_pkg::sha_sts_t sts,
	output sha_pkg::sha_cmd_t cmd
);
	import sha_pkg::*;

	sha_state_t state_q, state_d;
	sha_state_t ret_q, ret_d;
	logic [5:0] round_q, round_d;
	logic [2:0] widx_q, widx_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ret_q <= ST_IDLE;
			round_q <= '0;
			widx_q <= '0;
		end else begin
			state_q <= state_d;
			ret_q <= ret_d;
			round_q <= round_d;
			widx_q <= widx_d;
		end
	end

	always_comb begin
		state_d = state_q;
		ret_d = ret_q;
		round_d = round_q;
		widx_d = widx_q;
		in_ready = 1'b0;
		out_valid = 1'b0;
		cmd = '0;
		cmd.bsel = BSEL_DATA;
		cmd.round_idx = round_q;
		cmd.word_idx = widx_q;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (byte_present) begin
						cmd.push = 1'b1;
						cmd.add_len = 1'b1;
					end
					if (byte_present && sts.pos == POS_LAST) begin
						cmd.init_work = 1'b1;
						state_d = ST_ROUND;
						ret_d = last_byte ? ST_MARK : ST_IDLE;
					end else if (last_byte) begin
						state_d = ST_MARK;
					end
				end
			end
			ST_MARK: begin
				cmd.push = 1'b1;
				cmd.bsel = BSEL_MARK;
				if (sts.pos == POS_LAST) begin
					cmd.init_work = 1'b1;
					state_d = ST_ROUND;
					ret_d = ST_ZERO;
				end else begin
					state_d = ST_ZERO;
				end
			end
			ST_ZERO: begin
				if (sts.pos == POS_LEN) begin
					state_d = ST_LEN;
				end else begin
					cmd.push = 1'b1;
					cmd.bsel = BSEL_ZERO;
					if (sts.pos == POS_LAST) begin
						cmd.init_work = 1'b1;
						state_d = ST_ROUND;
						ret_d = ST_ZERO;
					end
				end
			end
			ST_LEN: begin
				cmd.push = 1'b1;
				cmd.bsel = BSEL_LEN;
				if (sts.pos == POS_LAST) begin
					cmd.init_work = 1'b1;
					state_d = ST_ROUND;
					ret_d = ST_OUT;
				end
			end
			ST_ROUND: begin
				cmd.do_round = 1'b1;
				round_d = round_q + 6'd1;
				if (round_q == ROUND_LAST) begin
					state_d = ST_FOLD;
				end
			end
			ST_FOLD: begin
				cmd.fold = 1'b1;
				state_d = ret_q;
			end
			ST_OUT: begin
				out_valid = 1'b1;
				if (out_ready) begin
					widx_d = widx_q + 3'd1;
					if (widx_q == WORD_LAST) begin
						cmd.rst_msg = 1'b1;
						state_d = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule
`default_nettype wire

>>> rtl/sha_dp.sv
// sha_dp: SHA-256 datapath: block word line, round variables, hash state, bit length.
// Depends on sha_pkg; steered by sha_ctrl through sha_cmd_t.
`default_nettype none
module sha_dp (
	input  wire               clk,
	input  wire               arst_n,
	input  wire sha_pkg::sha_cmd_t cmd,
	input  wire  [7:0]        data_byte,
	output sha_pkg::sha_sts_t sts,
	output logic [31:0]       digest_word
);
	import sha_pkg::*;

	logic [31:0] words_q [BLOCK_WORDS];
	logic [31:0] work_q [HASH_WORDS];
	logic [31:0] hash_q [HASH_WORDS];
	logic [5:0]  pos_q;
	logic [63:0] len_q;

	logic [7:0]  push_byte;
	logic [31:0] w_next;
	logic [31:0] t1;
	logic [31:0] t2;
	logic [31:0] ch;
	logic [31:0] maj;

	always_comb begin
		case (cmd.bsel)
			BSEL_DATA: push_byte = data_byte;
			BSEL_MARK: push_byte = PAD_MARK;
			BSEL_ZERO: push_byte = '0;
			BSEL_LEN:  push_byte = len_q[{~pos_q[2:0], 3'b000} +: 8];
			default:   push_byte = '0;
		endcase
	end

	assign w_next = small_s1(words_q[14]) + words_q[9] + small_s0(words_q[1]) + words_q[0];
	assign ch = (work_q[4] & work_q[5]) ^ (~work_q[4] & work_q[6]);
	assign maj = (work_q[0] & work_q[1]) ^ (work_q[0] & work_q[2]) ^ (work_q[1] & work_q[2]);
	assign t1 = work_q[7] + big_s1(work_q[4]) + ch + ROUND_K[cmd.round_idx] + words_q[0];
	assign t2 = big_s0(work_q[0]) + maj;

	always_ff @(posedge clk) begin
		if (cmd.push) begin
			for (int i = 0; i < BLOCK_WORDS - 1; i++) begin
				words_q[i] <= {words_q[i][23:0], words_q[i + 1][31:24]};
			end
			words_q[BLOCK_WORDS - 1] <= {words_q[BLOCK_WORDS - 1][23:0], push_byte};
		end else if (cmd.do_round) begin
			for (int i = 0; i < BLOCK_WORDS - 1; i++) begin
				words_q[i] <= words_q[i + 1];
			end
			words_q[BLOCK_WORDS - 1] <= w_next;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.init_work) begin
			for (int i = 0; i < HASH_WORDS; i++) begin
				work_q[i] <= hash_q[i];
			end
		end else if (cmd.do_round) begin
			work_q[7] <= work_q[6];
			work_q[6] <= work_q[5];
			work_q[5] <= work_q[4];
			work_q[4] <= work_q[3] + t1;
			work_q[3] <= work_q[2];
			work_q[2] <= work_q[1];
			work_q[1] <= work_q[0];
			work_q[0] <= t1 + t2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < HASH_WORDS; i++) begin
				hash_q[i] <= HASH_IV[i];
			end
			pos_q <= '0;
			len_q <= '0;
		end else begin
			if (cmd.rst_msg) begin
				for (int i = 0; i < HASH_WORDS; i++) begin
					hash_q[i] <= HASH_IV[i];
				end
			end else if (cmd.fold) begin
				for (int i = 0; i < HASH_WORDS; i++) begin
					hash_q[i] <= hash_q[i] + work_q[i];
				end
			end
			if (cmd.push) begin
				pos_q <= pos_q + 6'd1;
			end else if (cmd.rst_msg) begin
				pos_q <= '0;
			end
			if (cmd.rst_msg) begin
				len_q <= '0;
			end else if (cmd.add_len) begin
				len_q <= len_q + LEN_STEP;
			end
		end
	end

	assign sts.pos = pos_q;
	assign digest_word = hash_q[cmd.word_idx];

endmodule
`default_nettype wire

>>> bench/testbench.sv
// Testbench for sha256_hash_engine: feeds byte-serial messages and checks every digest word.
// Holds its own SHA-256 predictor; needs the sha_pkg package, the channel interfaces and the RTL.
`timescale 1ns / 1ps
module testbench;

	localparam bit [31:0] START_HASH [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam bit [31:0] ROUND_CONST [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	localparam bit [7:0] PAD_BYTE = 8'h80;
	localparam bit [5:0] LENGTH_POS = 6'd56;
	localparam bit [2:0] FINAL_INDEX = 3'd7;
	localparam int PHASE_ITEMS = 72;

	typedef struct packed {
		logic [31:0] word;
		logic [2:0]  index;
		logic        tail;
	} digest_word_t;

	class sha256_scoreboard;
		bit [31:0] chain [8];
		bit [31:0] block_words [16];
		bit [5:0] fill_pos;
		bit [63:0] bit_len;
		digest_word_t digest_queue [$];
		int failures;

		function new();
			failures = 0;
			restart();
		endfunction

		function void restart();
			for (int i = 0; i < 8; i++)
				chain[i] = START_HASH[i];
			fill_pos = '0;
			bit_len = '0;
		endfunction

		function bit [31:0] ror(bit [31:0] x, int n);
			return (x >> n) | (x << (32 - n));
		endfunction

		function void compress();
			bit [31:0] w [64];
			bit [31:0] v [8];
			bit [31:0] t1, t2, s0, s1, ch, mj;
			for (int t = 0; t < 64; t++) begin
				if (t < 16) begin
					w[t] = block_words[t];
				end else begin
					s0 = ror(w[t-15], 7) ^ ror(w[t-15], 18) ^ (w[t-15] >> 3);
					s1 = ror(w[t-2], 17) ^ ror(w[t-2], 19) ^ (w[t-2] >> 10);
					w[t] = s1 + w[t-7] + s0 + w[t-16];
				end
			end
			for (int i = 0; i < 8; i++)
				v[i] = chain[i];
			for (int t = 0; t < 64; t++) begin
				s1 = ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25);
				ch = (v[4] & v[5]) ^ (~v[4] & v[6]);
				t1 = v[7] + s1 + ch + ROUND_CONST[t] + w[t];
				s0 = ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22);
				mj = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
				t2 = s0 + mj;
				v[7] = v[6];
				v[6] = v[5];
				v[5] = v[4];
				v[4] = v[3] + t1;
				v[3] = v[2];
				v[2] = v[1];
				v[1] = v[0];
				v[0] = t1 + t2;
			end
			for (int i = 0; i < 8; i++)
				chain[i] += v[i];
		endfunction

		function void absorb(bit [7:0] b);
			block_words[fill_pos[5:2]][8 * (3 - fill_pos[1:0]) +: 8] = b;
			fill_pos++;
			if (fill_pos == '0)
				compress();
		endfunction

		function void note_item(bit [7:0] data, bit present, bit is_last);
			bit [63:0] len;
			digest_word_t e;
			if (present) begin
				absorb(data);
				bit_len += 64'd8;
			end
			if (!is_last)
				return;
			len = bit_len;
			absorb(PAD_BYTE);
			while (fill_pos != LENGTH_POS)
				absorb(8'h00);
			for (int s = 7; s >= 0; s--)
				absorb(len[8 * s +: 8]);
			for (int k = 0; k < 8; k++) begin
				e.word = chain[k];
				e.index = 3'(k);
				e.tail = (3'(k) == FINAL_INDEX);
				digest_queue = {digest_queue, e};
			end
			restart();
		endfunction

		function void check_word(bit [31:0] word, bit [2:0] index, bit tail);
			digest_word_t e;
			if (digest_queue.size() == 0) begin
				$error("unexpected digest item: digest_word %h word_index %0d", word, index);
				failures++;
				return;
			end
			e = digest_queue.pop_front();
			if (word != e.word) begin
				$error("digest_word expected %h actual %h", e.word, word);
				failures++;
			end
			if (index != e.index) begin
				$error("word_index expected %0d actual %0d", e.index, index);
				failures++;
			end
			if (tail != e.tail) begin
				$error("last_word expected %0d actual %0d", e.tail, tail);
				failures++;
			end
		endfunction

		function int outstanding();
			return digest_queue.size();
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	int idle_pct;
	int stall_pct;
	int sent_items;
	sha256_scoreboard hash_board;

	sha_byte_if msg_ch ();
	sha_digest_if digest_ch ();

	sha256_hash_engine DUT (
		.clk(clk),
		.arst_n(arst_n),
		.msg(msg_ch),
		.digest(digest_ch)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		digest_ch.ready <= ($urandom_range(99) >= stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n && digest_ch.valid && digest_ch.ready)
			hash_board.check_word(digest_ch.digest_word, digest_ch.word_index,
				digest_ch.last_word);
	end

	task automatic send_item(input bit [7:0] data, input bit present, input bit is_last);
		while ($urandom_range(99) < idle_pct) begin
			msg_ch.valid <= 1'b0;
			@(posedge clk);
		end
		msg_ch.valid <= 1'b1;
		msg_ch.data_byte <= data;
		msg_ch.byte_present <= present;
		msg_ch.last_byte <= is_last;
		do @(posedge clk); while (!msg_ch.ready);
		hash_board.note_item(data, present, is_last);
		sent_items++;
	endtask

	task automatic send_message(input int len, input bit separate_end);
		for (int i = 0; i < len; i++) begin
			if ($urandom_range(99) < 8)
				send_item(8'($urandom_range(255)), 1'b0, 1'b0);
			send_item(8'($urandom_range(255)), 1'b1, (i == len - 1) && !separate_end);
		end
		if (separate_end || len == 0)
			send_item(8'($urandom_range(255)), 1'b0, 1'b1);
	endtask

	function automatic int pick_length();
		int r;
		int edges [8] = '{55, 56, 57, 63, 64, 65, 119, 120};
		r = $urandom_range(99);
		if (r < 60)
			return $urandom_range(12);
		if (r < 90)
			return $urandom_range(40);
		return edges[$urandom_range(7)];
	endfunction

	initial begin
		int target;
		int msg_len;
		hash_board = new();
		idle_pct = 0;
		stall_pct = 0;
		sent_items = 0;
		arst_n = 1'b0;
		msg_ch.valid = 1'b0;
		msg_ch.data_byte = 8'h00;
		msg_ch.byte_present = 1'b0;
		msg_ch.last_byte = 1'b0;
		digest_ch.ready = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_item(8'h00, 1'b0, 1'b1);
		send_item(8'h61, 1'b1, 1'b0);
		send_item(8'h62, 1'b1, 1'b0);
		send_item(8'h63, 1'b1, 1'b1);
		send_item(8'h3c, 1'b0, 1'b0);
		send_item(8'hff, 1'b1, 1'b1);
		send_item(8'h00, 1'b1, 1'b0);
		send_item(8'hff, 1'b0, 1'b1);
		send_item(8'ha5, 1'b1, 1'b0);
		send_item(8'h5a, 1'b0, 1'b0);
		send_item(8'h5a, 1'b1, 1'b0);
		send_item(8'h00, 1'b0, 1'b1);
		send_item(8'hff, 1'b0, 1'b1);
		send_item(8'h80, 1'b1, 1'b0);
		send_item(8'h7f, 1'b1, 1'b1);

		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 69; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 69; end
				default: begin idle_pct = 33; stall_pct = 33; end
			endcase
			target = sent_items + PHASE_ITEMS;
			while (sent_items < target) begin
				msg_len = pick_length();
				if (msg_len > target - sent_items)
					msg_len = target - sent_items;
				send_message(msg_len, 1'($urandom_range(1)));
			end
		end
		msg_ch.valid <= 1'b0;

		while (hash_board.outstanding() != 0)
			@(posedge clk);
		repeat (200) @(posedge clk);
		if (hash_board.failures == 0 && hash_board.outstanding() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	initial begin
		#2000000;
		$display("CHECK FAILED");
		$finish;
	end

endmodule
